### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/gmc_pkg.sv
// Package for the graph coloring unit: widths, codes and the microcode table.
package gmc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ROW_W        = 32;
    localparam int COLOR_W      = 6;
    localparam int IDX_W        = 5;
    localparam int CFG_W        = 6;

    localparam logic [CFG_W-1:0] NUM_COLORS_RST   = 6'd3;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 6'd32;

    typedef enum logic {
        CFG_NUM_COLORS   = 1'b0,
        CFG_VERTEX_COUNT = 1'b1
    } t_cfg_reg;

    // microcode addresses
    typedef enum logic [3:0] {
        P_WAIT, P_INIT, P_READ, P_TRY, P_TEST,
        P_PLACE, P_BACK, P_OK, P_FAIL, P_EMIT
    } t_step;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_READ, OP_TEST,
        OP_PLACE, OP_BACK, OP_OK, OP_FAIL, OP_EMIT
    } t_op;

    // branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS, C_LAST_ROW, C_OVER, C_FITS, C_V_LAST, C_V_ZERO
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            P_WAIT:  w = '{OP_LOAD,  C_LAST_ROW, P_INIT,  P_WAIT};
            P_INIT:  w = '{OP_INIT,  C_ALWAYS,   P_READ,  P_READ};
            P_READ:  w = '{OP_READ,  C_ALWAYS,   P_TRY,   P_TRY};
            P_TRY:   w = '{OP_NONE,  C_OVER,     P_BACK,  P_TEST};
            P_TEST:  w = '{OP_TEST,  C_FITS,     P_PLACE, P_TRY};
            P_PLACE: w = '{OP_PLACE, C_V_LAST,   P_OK,    P_READ};
            P_BACK:  w = '{OP_BACK,  C_V_ZERO,   P_FAIL,  P_READ};
            P_OK:    w = '{OP_OK,    C_ALWAYS,   P_EMIT,  P_EMIT};
            P_FAIL:  w = '{OP_FAIL,  C_ALWAYS,   P_EMIT,  P_EMIT};
            P_EMIT:  w = '{OP_EMIT,  C_V_LAST,   P_WAIT,  P_EMIT};
            default: w = '{OP_NONE,  C_ALWAYS,   P_WAIT,  P_WAIT};
        endcase
        return w;
    endfunction

endpackage

### design/graph_m_coloring_backtrack_unit.sv
// Top level: graph m-coloring by backtracking search, microcoded sequencer.
//
// Usage
//   Load: one adjacency row per word on i_row_bits, accepted at a clock edge
//   with start high and busy low. Bit i of the row marks vertex i adjacent.
//   Rows load one per cycle. The word that completes vertex_count rows
//   starts the search; busy rises on the next cycle.
//   Search: data-dependent depth-first backtracking after a setup step. Each
//   vertex visit reads its row from the RAM, then range-checks and tests
//   candidate colors in turn, places the first that fits or, if none is
//   left, clears the vertex and backs off. A last step records the verdict.
//   Results: one word per vertex, in vertex order, on consecutive cycles,
//   output by the emit step after the verdict, each marked by o_strobe for one
//   cycle. o_last_vertex flags the final one; busy falls with it and a new
//   load can begin. The receiver cannot stall: results are never held back.
//   Config: i_cfg_valid/o_cfg_ready write num_colors (index 0) or
//   vertex_count (index 1); o_cfg_ready is always high. Write only while idle.
//   Reset (synchronous, active low): sequencer to idle, zero rows loaded,
//   num_colors = 3, vertex_count = 32.
module graph_m_coloring_backtrack_unit #(
    parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gmc_pkg::ROW_W-1:0]    i_row_bits,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [gmc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_strobe,
    output logic [gmc_pkg::IDX_W-1:0]    o_vertex_index,
    output logic [gmc_pkg::COLOR_W-1:0]  o_vertex_color,
    output logic                         o_solution_found,
    output logic                         o_last_vertex
);

    // vertices actually searched: rows are 32 bits wide
    localparam int NV  = (MAX_VERTICES < gmc_pkg::ROW_W) ? MAX_VERTICES : gmc_pkg::ROW_W;
    localparam int VW  = $clog2(NV);
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int RLW = $clog2(MAX_VERTICES + 1);
    localparam int CW  = gmc_pkg::COLOR_W;

    // sequencer
    gmc_pkg::t_step  r_pc, n_pc;
    gmc_pkg::t_uword w_uw;

    // config registers
    logic [gmc_pkg::CFG_W-1:0] r_num_colors, r_vertex_count;

    // datapath registers
    logic [RLW-1:0] r_rows, n_rows;
    logic [VW-1:0]  r_v, n_v;
    logic [CW-1:0]  r_cand, n_cand;
    logic [CW-1:0]  r_color [NV];
    logic [CW-1:0]  n_color [NV];
    logic           r_found, n_found;

    // result registers
    logic                        r_strobe, n_strobe;
    logic [gmc_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [CW-1:0]               r_ocolor, n_ocolor;
    logic                        r_ofound, n_ofound;
    logic                        r_olast, n_olast;

    // decoded conditions
    logic                        w_accept;
    logic                        w_last_row;
    logic                        w_over;
    logic                        w_fits;
    logic                        w_v_last;
    logic                        w_v_zero;
    logic                        w_take;
    logic [gmc_pkg::CFG_W-1:0]   w_n;
    logic [gmc_pkg::ROW_W-1:0]   w_row;
    logic [NV-1:0]               w_hit;
    logic                        w_ram_we;
    logic                        w_ram_re;

    assign busy        = (r_pc != gmc_pkg::P_WAIT);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_uw        = gmc_pkg::ucode(r_pc);

    // effective vertex count: at least 1, at most NV
    always_comb begin
        if (r_vertex_count == '0) begin
            w_n = gmc_pkg::CFG_W'(1);
        end else if (r_vertex_count > gmc_pkg::CFG_W'(NV)) begin
            w_n = gmc_pkg::CFG_W'(NV);
        end else begin
            w_n = r_vertex_count;
        end
    end

    assign w_last_row = ((RLW+1)'(r_rows) + (RLW+1)'(1)) >= (RLW+1)'(w_n);
    assign w_over     = r_cand > r_num_colors;
    assign w_v_last   = gmc_pkg::CFG_W'(r_v) == (w_n - gmc_pkg::CFG_W'(1));
    assign w_v_zero   = (r_v == '0);

    // adjacency row of r_v, read at P_READ, held by the RAM afterwards
    gmc_ram #(
        .WIDTH (gmc_pkg::ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_rows[AW-1:0]),
        .i_wdata (i_row_bits),
        .i_re    (w_ram_re),
        .i_raddr (AW'(r_v)),
        .o_rdata (w_row)
    );

    assign w_ram_we = (w_uw.op == gmc_pkg::OP_LOAD) && w_accept
                      && (r_rows < RLW'(MAX_VERTICES));
    assign w_ram_re = (w_uw.op == gmc_pkg::OP_READ);

    // conflict check: any in-range neighbor other than v holding the candidate
    always_comb begin
        for (int i = 0; i < NV; i++) begin
            w_hit[i] = w_row[i] && (gmc_pkg::CFG_W'(i) < w_n) && (VW'(i) != r_v)
                       && (r_color[i] == r_cand);
        end
    end
    assign w_fits = ~|w_hit;

    // branch select
    always_comb begin
        case (w_uw.cond)
            gmc_pkg::C_ALWAYS:   w_take = 1'b1;
            gmc_pkg::C_LAST_ROW: w_take = w_accept && w_last_row;
            gmc_pkg::C_OVER:     w_take = w_over;
            gmc_pkg::C_FITS:     w_take = w_fits;
            gmc_pkg::C_V_LAST:   w_take = w_v_last;
            gmc_pkg::C_V_ZERO:   w_take = w_v_zero;
            default:             w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.tgt_t : w_uw.tgt_f;
    end

    // datapath driven by the control word
    always_comb begin
        n_rows   = r_rows;
        n_v      = r_v;
        n_cand   = r_cand;
        n_color  = r_color;
        n_found  = r_found;
        n_strobe = 1'b0;
        n_idx    = r_idx;
        n_ocolor = r_ocolor;
        n_ofound = r_ofound;
        n_olast  = r_olast;
        case (w_uw.op)
            gmc_pkg::OP_LOAD: begin
                if (w_accept) begin
                    n_rows = r_rows + RLW'(1);
                end
            end
            gmc_pkg::OP_INIT: begin
                n_rows = '0;
                n_v    = '0;
                for (int i = 0; i < NV; i++) begin
                    n_color[i] = '0;
                end
            end
            gmc_pkg::OP_READ: begin
                n_cand = r_color[r_v] + CW'(1);
            end
            gmc_pkg::OP_TEST: begin
                if (!w_fits) begin
                    n_cand = r_cand + CW'(1);
                end
            end
            gmc_pkg::OP_PLACE: begin
                n_color[r_v] = r_cand;
                n_v          = r_v + VW'(1);
            end
            gmc_pkg::OP_BACK: begin
                n_color[r_v] = '0;
                n_v          = r_v - VW'(1);
            end
            gmc_pkg::OP_OK: begin
                n_found = 1'b1;
                n_v     = '0;
            end
            gmc_pkg::OP_FAIL: begin
                n_found = 1'b0;
                n_v     = '0;
            end
            gmc_pkg::OP_EMIT: begin
                n_strobe = 1'b1;
                n_idx    = gmc_pkg::IDX_W'(r_v);
                n_ocolor = r_color[r_v];
                n_ofound = r_found;
                n_olast  = w_v_last;
                n_v      = r_v + VW'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc           <= gmc_pkg::P_WAIT;
            r_rows         <= '0;
            r_strobe       <= 1'b0;
            r_num_colors   <= gmc_pkg::NUM_COLORS_RST;
            r_vertex_count <= gmc_pkg::VERTEX_COUNT_RST;
        end else begin
            r_pc     <= n_pc;
            r_rows   <= n_rows;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (gmc_pkg::t_cfg_reg'(i_cfg_index))
                    gmc_pkg::CFG_NUM_COLORS:   r_num_colors   <= i_cfg_data;
                    gmc_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                    default:                   r_num_colors   <= r_num_colors;
                endcase
            end
        end
    end

    // payload, not reset; vertex index and colors are cleared by the search setup step
    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_cand   <= n_cand;
        r_color  <= n_color;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_ocolor <= n_ocolor;
        r_ofound <= n_ofound;
        r_olast  <= n_olast;
    end

    assign o_strobe         = r_strobe;
    assign o_vertex_index   = r_idx;
    assign o_vertex_color   = r_ocolor;
    assign o_solution_found = r_ofound;
    assign o_last_vertex    = r_olast;

endmodule

### design/gmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/gmc_checker.sv
// Port-level checker for the graph coloring unit, bound to the top level.
`include "assert_macros.svh"

module gmc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [gmc_pkg::IDX_W-1:0]    o_vertex_index,
    input logic [gmc_pkg::COLOR_W-1:0]  o_vertex_color,
    input logic                         o_solution_found,
    input logic                         o_last_vertex
);

    // result burst runs on consecutive cycles with rising vertex index
    `ASSERT_NEXT(a_burst_seq, o_strobe && !o_last_vertex, o_strobe && (o_vertex_index == $past(o_vertex_index) + gmc_pkg::IDX_W'(1)), "result burst broken or out of order")

    // each burst opens with vertex 0
    `ASSERT_SAME(a_burst_first, $rose(o_strobe), o_vertex_index == '0, "burst does not start at vertex 0")

    // no coloring means every color reads zero
    `ASSERT_SAME(a_fail_zero, o_strobe && !o_solution_found, o_vertex_color == '0, "nonzero color without a solution")

    // more results pending keeps the unit busy
    `ASSERT_SAME(a_busy_burst, o_strobe && !o_last_vertex, busy, "idle while results pending")

    // found flag is the same across one burst
    `ASSERT_SAME(a_found_stable, o_strobe && $past(o_strobe) && !$past(o_last_vertex), o_solution_found == $past(o_solution_found), "found flag changed within burst")

endmodule

bind graph_m_coloring_backtrack_unit gmc_checker u_gmc_checker (.*);

### sim/tb_graph_m_coloring_backtrack_unit.sv
// Testbench for graph_m_coloring_backtrack_unit: random graphs against a backtracking solver.
`timescale 1ns / 1ps

typedef logic [gmc_pkg::ROW_W-1:0]   t_adj_matrix [gmc_pkg::MAX_VERTICES];
typedef logic [gmc_pkg::COLOR_W-1:0] t_color_map  [gmc_pkg::MAX_VERTICES];

typedef struct packed {
    logic [gmc_pkg::IDX_W-1:0]   index;
    logic [gmc_pkg::COLOR_W-1:0] color;
    logic                        found;
    logic                        last;
} t_vertex_word;

class coloring_scoreboard;
    t_adj_matrix                 adj_rows;
    int                          rows_loaded;
    logic [gmc_pkg::CFG_W-1:0]   num_colors;
    logic [gmc_pkg::CFG_W-1:0]   vertex_count;
    t_vertex_word                expected_words[$];
    int                          mismatches;

    function new();
        foreach (adj_rows[i]) adj_rows[i] = '0;
        rows_loaded  = 0;
        num_colors   = gmc_pkg::NUM_COLORS_RST;
        vertex_count = gmc_pkg::VERTEX_COUNT_RST;
        mismatches   = 0;
    endfunction

    // count of 0 acts as 1, anything above the array size is capped
    function int active_vertices(input logic [gmc_pkg::CFG_W-1:0] count);
        int n;
        n = count;
        if (n < 1) n = 1;
        if (n > gmc_pkg::MAX_VERTICES) n = gmc_pkg::MAX_VERTICES;
        return n;
    endfunction

    // Depth-first search, lowest fitting color first. cycles is a rough
    // sequencer cost; the walk stops early once it passes budget.
    function void solve_coloring(input t_adj_matrix adj, input int n, input int palette,
                                 input int budget, output t_color_map colors,
                                 output bit found, output int cycles);
        int  v, c, i;
        bit  placed, fits, done;
        foreach (colors[k]) colors[k] = '0;
        v      = 0;
        cycles = 1;
        found  = 1'b0;
        done   = 1'b0;
        while (!done) begin
            if (v >= n) begin
                found = 1'b1;
                done  = 1'b1;
            end else if (cycles > budget) begin
                done = 1'b1;
            end else begin
                cycles += 1;
                placed = 1'b0;
                for (c = int'(colors[v]) + 1; c <= palette && !placed; c++) begin
                    cycles += 2;
                    fits = 1'b1;
                    // own bit never blocks a color
                    for (i = 0; i < n; i++)
                        if (i != v && adj[v][i] && int'(colors[i]) == c) fits = 1'b0;
                    if (fits) begin
                        colors[v] = c[gmc_pkg::COLOR_W-1:0];
                        placed    = 1'b1;
                    end
                end
                cycles += 2;
                if (placed) begin
                    v++;
                end else begin
                    colors[v] = '0;
                    if (v == 0) done = 1'b1;
                    else v--;
                end
            end
        end
    endfunction

    function void note_cfg(input gmc_pkg::t_cfg_reg sel,
                           input logic [gmc_pkg::CFG_W-1:0] value);
        if (sel == gmc_pkg::CFG_NUM_COLORS) num_colors = value;
        else vertex_count = value;
    endfunction

    function void note_row(input logic [gmc_pkg::ROW_W-1:0] row);
        int           n, cyc, k;
        bit           ok;
        t_color_map   colors;
        t_vertex_word w;
        n = active_vertices(vertex_count);
        if (rows_loaded < gmc_pkg::MAX_VERTICES) adj_rows[rows_loaded] = row;
        rows_loaded++;
        if (rows_loaded < n) return;
        solve_coloring(adj_rows, n, num_colors, 32'h7fffffff, colors, ok, cyc);
        for (k = 0; k < n; k++) begin
            w.index = k[gmc_pkg::IDX_W-1:0];
            w.color = colors[k];
            w.found = ok;
            w.last  = (k == n - 1);
            expected_words.push_back(w);
        end
        rows_loaded = 0;
    endfunction

    function void check_result(input logic [gmc_pkg::IDX_W-1:0] index,
                               input logic [gmc_pkg::COLOR_W-1:0] color,
                               input logic found, input logic last);
        t_vertex_word w;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: idx=%0d color=%0d found=%b last=%b",
                         index, color, found, last);
            return;
        end
        w = expected_words.pop_front();
        if (index !== w.index || color !== w.color || found !== w.found || last !== w.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp idx=%0d color=%0d found=%b last=%b, ",
                          "got idx=%0d color=%0d found=%b last=%b"},
                         w.index, w.color, w.found, w.last, index, color, found, last);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb_graph_m_coloring_backtrack_unit;

    localparam int N_ITEMS        = 320;   // rows to send in the whole run
    localparam int IDLE_PCT       = 22;    // sender idle chance per cycle
    localparam int SEARCH_BUDGET  = 5000;  // graphs costing more are redrawn
    localparam int WATCHDOG_LIMIT = 40000; // quiet cycles before giving up
    localparam int SETTLE_CYCLES  = 8;     // slack after the last result

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [gmc_pkg::ROW_W-1:0]   i_row_bits;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic                        i_cfg_index;
    logic [gmc_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        o_strobe;
    logic [gmc_pkg::IDX_W-1:0]   o_vertex_index;
    logic [gmc_pkg::COLOR_W-1:0] o_vertex_color;
    logic                        o_solution_found;
    logic                        o_last_vertex;

    coloring_scoreboard sb;
    int                 quiet_cycles = 0;
    int                 rows_sent = 0;
    bit                 calm = 1'b0;   // set: sender never idles

    graph_m_coloring_backtrack_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_row_bits       (i_row_bits),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_vertex_index   (o_vertex_index),
        .o_vertex_color   (o_vertex_color),
        .o_solution_found (o_solution_found),
        .o_last_vertex    (o_last_vertex)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates land. Results are checked before a row is noted so a
    // finishing search and a new load on the same edge stay in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result(o_vertex_index, o_vertex_color, o_solution_found,
                                o_last_vertex);
            if (start && !busy)
                sb.note_row(i_row_bits);
            if (i_cfg_valid && o_cfg_ready)
                sb.note_cfg(gmc_pkg::t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a search is bounded by SEARCH_BUDGET, so a long quiet spell
    // means the block hung.
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL graph_m_coloring_backtrack_unit");
            $finish;
        end
    end

    // One row word. start stays high across back-to-back rows; an idle
    // cycle drops it first. While busy the word simply waits.
    task automatic send_row(input logic [gmc_pkg::ROW_W-1:0] row);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_row_bits <= row;
        do @(posedge i_clk); while (busy);
        rows_sent++;
    endtask

    // Stop sending and wait for the block to go idle: all words out, plus
    // SETTLE_CYCLES of slack for a row that produced nothing.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input gmc_pkg::t_cfg_reg sel,
                             input logic [gmc_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [gmc_pkg::CFG_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 65) return gmc_pkg::CFG_W'($urandom_range(0, 8));
        if (r < 90) return gmc_pkg::CFG_W'($urandom_range(9, 20));
        return gmc_pkg::CFG_W'($urandom_range(21, 63));
    endfunction

    function automatic logic [gmc_pkg::CFG_W-1:0] pick_colors();
        int r;
        r = $urandom_range(99);
        if (r < 60) return gmc_pkg::CFG_W'($urandom_range(0, 4));
        if (r < 85) return gmc_pkg::CFG_W'($urandom_range(5, 8));
        return gmc_pkg::CFG_W'($urandom_range(0, 63));
    endfunction

    // Random graph on n vertices, mostly symmetric. Bits outside the n x n
    // block, self bits and unused rows are random junk. Graphs whose search
    // would run too long are redrawn; the last try has no edges at all.
    task automatic pick_graph(output t_adj_matrix g, input int n);
        int         tries, p, i, j, cyc;
        bit         sym, ok, done, edge_on;
        t_color_map colors;
        done = 1'b0;
        for (tries = 0; tries < 40 && !done; tries++) begin
            if (tries == 39) p = 0;
            else if (n <= 8) p = $urandom_range(0, 100);
            else p = $urandom_range(0, 35);
            sym = ($urandom_range(3) != 0);
            foreach (g[k]) g[k] = $urandom;
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++) begin
                    if (sym && j > i) begin
                        edge_on = ($urandom_range(99) < p);
                        g[i][j] = edge_on;
                        g[j][i] = edge_on;
                    end else if (!sym && j != i) begin
                        g[i][j] = ($urandom_range(99) < p);
                    end
                end
            sb.solve_coloring(g, n, sb.num_colors, SEARCH_BUDGET, colors, ok, cyc);
            done = (cyc <= SEARCH_BUDGET);
        end
    endtask

    // One full load. split > 0 stops after that many rows, rewrites the
    // vertex count while idle and finishes the load under the new count.
    task automatic run_graph(input int split, input logic [gmc_pkg::CFG_W-1:0] count_b);
        t_adj_matrix g;
        int          n, total, i;
        n = (split == 0) ? sb.active_vertices(sb.vertex_count)
                         : sb.active_vertices(count_b);
        total = (split >= n) ? split + 1 : n;
        pick_graph(g, n);
        for (i = 0; i < split; i++) send_row(g[i]);
        if (split > 0) begin
            drain();
            write_cfg(gmc_pkg::CFG_VERTEX_COUNT, count_b);
        end
        for (i = split; i < total; i++) send_row(g[i]);
    endtask

    initial begin
        int phase, n, v;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_row_bits  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gmc_pkg::CFG_NUM_COLORS;
        i_cfg_data  = '0;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset settings: 32 vertices, 3 colors; an even ring alternates 1/2
        for (v = 0; v < gmc_pkg::MAX_VERTICES; v++)
            send_row((32'd1 << ((v + 1) % 32)) | (32'd1 << ((v + 31) % 32)));

        // no colors at all: nothing can be placed
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd0);
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd1);
        send_row(32'hFFFF_FFFF);

        // count 0 acts as one vertex; a self loop does not block
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd1);
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd0);
        send_row(32'h0000_0001);

        // triangle, two colors: search backtracks all the way and fails
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd2);
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd3);
        send_row(32'h0000_0006);
        send_row(32'h0000_0005);
        send_row(32'h0000_0003);

        // same triangle with three colors
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd3);
        send_row(32'h0000_0006);
        send_row(32'h0000_0005);
        send_row(32'h0000_0003);

        // one-sided edge: vertex 1 only sees its own row; junk above count
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd2);
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd2);
        send_row(32'h0000_0002);
        send_row(32'hFFFF_FFFC);

        // count lowered below the rows already loaded: next row searches
        drain();
        write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd3);
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd6);
        send_row($urandom);
        send_row($urandom);
        send_row($urandom);
        drain();
        write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd2);
        send_row($urandom);

        // random part; the drains before config writes give the full
        // pause-until-empty case, other loads follow back to back
        phase = 0;
        while (rows_sent < N_ITEMS) begin
            calm = (rows_sent >= 130 && rows_sent < 210);
            if (phase == 0) begin
                // top of both ranges: 32 vertices, 63 colors
                drain();
                write_cfg(gmc_pkg::CFG_NUM_COLORS, 6'd63);
                write_cfg(gmc_pkg::CFG_VERTEX_COUNT, 6'd63);
                run_graph(0, '0);
            end else begin
                if ($urandom_range(99) < 45) begin
                    drain();
                    write_cfg(gmc_pkg::CFG_NUM_COLORS, pick_colors());
                end
                if ($urandom_range(99) < 45) begin
                    drain();
                    write_cfg(gmc_pkg::CFG_VERTEX_COUNT, pick_count());
                end
                n = sb.active_vertices(sb.vertex_count);
                if (n >= 2 && $urandom_range(99) < 15)
                    run_graph($urandom_range(1, n - 1), pick_count());
                else
                    run_graph(0, '0);
            end
            phase++;
        end
        calm = 1'b0;

        // wait for the last words, then a margin for stray ones
        drain();
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS graph_m_coloring_backtrack_unit");
        end else begin
            $display("FAIL graph_m_coloring_backtrack_unit");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/gmc_pkg.sv
design/gmc_ram.sv
design/graph_m_coloring_backtrack_unit.sv
design/gmc_checker.sv
sim/tb_graph_m_coloring_backtrack_unit.sv
